// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, muted during reset.
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, including cycles in reset.
`define ITOA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/itoa_pkg.sv
// Types, constants and helpers for the integer to ASCII converter.
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned IN_BITS        = 64;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;

  typedef struct packed {
    logic [IN_BITS-1:0] value;
    logic               is_signed;
    logic               hex_mode;
  } num_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } chr_t;

  typedef struct packed {
    logic load;       // take a new request
    logic conv_step;  // one shift-add-3 step
    logic dig_shift;  // drop the top digit
    logic out_load;   // write the output register
    logic out_sign;   // output register gets '-'
    logic out_last;   // last marker for the written character
  } dp_cmd_t;

  typedef struct packed {
    logic hex_req;    // radix of the request at the input
    logic neg;        // stored number is negative
    logic top_zero;   // top digit of the buffer is zero
    logic out_busy;   // output register full and stalled
  } dp_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // Decimal digit count needed for a value of the given width.
  function automatic int unsigned dec_digits(input int unsigned bits);
    return (bits * 1233) / 4096 + 1;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_LOW_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/integer_to_ascii_digits.sv
// Integer to ASCII text converter, decimal or lower-case hexadecimal.
// Takes one number per request and sends its text one character per output
// request, most significant digit first, with last_char on the final one;
// a negative signed number gets a leading '-'. One number is in work at a
// time. A decimal number passes an accept step, the bit-serial shift-add-3
// converter over every input bit, a sign step and one step per digit
// position of the BCD buffer (dec_digits(VALUE_BITS), 20 for 64 bits);
// hexadecimal skips the converter. Output stalls hold the sequence only
// while a character waits to enter a full output register, not while the
// converter runs or leading zeros are dropped. The last character sits in
// the output register while the next number is taken.
module integer_to_ascii_digits #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           num_valid,
  output logic           num_stall,
  input  itoa_pkg::num_t num,
  output logic           chr_valid,
  input  logic           chr_stall,
  output itoa_pkg::chr_t chr
);
  import itoa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  itoa_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .num_valid(num_valid),
    .num_stall(num_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .num      (num),
    .cmd      (cmd),
    .sts      (sts),
    .chr_valid(chr_valid),
    .chr_stall(chr_stall),
    .chr      (chr)
  );

endmodule

// File: hw/rtl/itoa_datapath.sv
// Datapath: magnitude, BCD digit buffer and output register.
module itoa_datapath #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  itoa_pkg::num_t  num,
  input  itoa_pkg::dp_cmd_t cmd,
  output itoa_pkg::dp_sts_t sts,
  output logic            chr_valid,
  input  logic            chr_stall,
  output itoa_pkg::chr_t  chr
);
  import itoa_pkg::*;

  localparam int unsigned NDIG  = dec_digits(VALUE_BITS);
  localparam int unsigned DBITS = NDIG * 4;

  logic [VALUE_BITS-1:0] mag;
  logic [DBITS-1:0]      dig;
  logic [DBITS-1:0]      adj;
  logic                  neg;
  logic [VALUE_BITS-1:0] vin;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  neg_in;
  logic [3:0]            top;
  logic                  chr_valid_next;

  assign vin    = num.value[VALUE_BITS-1:0];
  assign neg_in = num.is_signed & vin[VALUE_BITS-1];
  assign mag_in = neg_in ? (~vin + 1'b1) : vin;
  assign top    = dig[DBITS-1 -: 4];

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_in;
      neg <= neg_in;
      dig <= num.hex_mode ? DBITS'(mag_in) : '0;
    end else if (cmd.conv_step) begin
      mag <= mag << 1;
      dig <= {adj[DBITS-2:0], mag[VALUE_BITS-1]};
    end else if (cmd.dig_shift) begin
      dig <= dig << 4;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      chr_valid_next = 1'b1;
    end else if (!chr_stall) begin
      chr_valid_next = 1'b0;
    end else begin
      chr_valid_next = chr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else begin
      chr_valid <= chr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      chr.char_code <= cmd.out_sign ? CHAR_MINUS : digit_char(top);
      chr.last_char <= cmd.out_last;
    end
  end

  assign sts.hex_req  = num.hex_mode;
  assign sts.neg      = neg;
  assign sts.top_zero = (top == 4'd0);
  assign sts.out_busy = chr_valid & chr_stall;

endmodule

// File: hw/rtl/itoa_ctrl.sv
// Controller: sequences conversion, sign and digit output.
module itoa_ctrl #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              num_valid,
  output logic              num_stall,
  input  itoa_pkg::dp_sts_t sts,
  output itoa_pkg::dp_cmd_t cmd
);
  import itoa_pkg::*;

  localparam int unsigned NDIG = dec_digits(VALUE_BITS);
  localparam int unsigned BCW  = $clog2(VALUE_BITS);
  localparam int unsigned DCW  = $clog2(NDIG + 1);

  state_t         state, state_next;
  logic [BCW-1:0] bit_cnt, bit_cnt_next;
  logic [DCW-1:0] dig_cnt, dig_cnt_next;
  logic           started, started_next;
  logic           accept;
  logic           last;
  logic           skip;

  assign num_stall = (state != ST_IDLE);
  assign accept    = num_valid & ~num_stall;
  assign last      = (dig_cnt == DCW'(1));
  assign skip      = ~started & sts.top_zero & ~last;

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    dig_cnt_next = dig_cnt;
    started_next = started;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load     = 1'b1;
          bit_cnt_next = BCW'(VALUE_BITS - 1);
          dig_cnt_next = DCW'(NDIG);
          started_next = 1'b0;
          state_next   = sts.hex_req ? ST_SIGN : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        bit_cnt_next  = bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!sts.neg) begin
          state_next = ST_EMIT;
        end else if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_sign = 1'b1;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip) begin
          cmd.dig_shift = 1'b1;
          dig_cnt_next  = dig_cnt - 1'b1;
        end else if (!sts.out_busy) begin
          cmd.dig_shift = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_last  = last;
          dig_cnt_next  = dig_cnt - 1'b1;
          started_next  = 1'b1;
          if (last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt <= bit_cnt_next;
    dig_cnt <= dig_cnt_next;
  end

endmodule

// File: hw/rtl/itoa_checker.sv
// Port-level checker for the integer to ASCII converter, bound to the top.
`include "assert_macros.svh"

module itoa_checker (
  input logic           clk,
  input logic           rst,
  input logic           num_valid,
  input logic           num_stall,
  input itoa_pkg::num_t num,
  input logic           chr_valid,
  input logic           chr_stall,
  input itoa_pkg::chr_t chr
);
  import itoa_pkg::*;

  // A taken request keeps the input stalled on the following cycle.
  `ITOA_ASSERT(a_busy_after_accept, (num_valid && !num_stall) |=> num_stall, "input not stalled after accept")

  // A stalled request holds its payload.
  `ITOA_ASSERT(a_in_hold, (num_valid && num_stall) |=> $stable(num), "request changed")

  // A minus sign is never the final character.
  `ITOA_ASSERT(a_sign_not_last, (chr_valid && chr.char_code == CHAR_MINUS) |-> !chr.last_char, "minus marked last")

  // A stalled character stays valid.
  `ITOA_ASSERT(a_out_hold, (chr_valid && chr_stall) |=> chr_valid, "output dropped under stall")

endmodule

bind integer_to_ascii_digits itoa_checker u_itoa_checker (.*);
